// ===== design/rskm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rskm_pkg;
   localparam int RUN_LEN   = 256;
   localparam int NUM_RUNS  = 10;
   localparam int TOTAL_LEN = RUN_LEN * NUM_RUNS;
   localparam int VAL_W     = 15;
   localparam int ADDR_W    = $clog2(TOTAL_LEN);
   localparam int CNT_W     = $clog2(TOTAL_LEN + 1);
   localparam int POS_W     = $clog2(RUN_LEN);
   localparam int HEAD_W    = $clog2(RUN_LEN + 1);
   localparam int RUN_W     = $clog2(NUM_RUNS);

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic             command;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] sorted_value;
      logic             is_last;
   } rsp_type;

   // address of position pos in run r
   function automatic logic [ADDR_W-1:0] run_addr(input logic [RUN_W-1:0] r,
                                                 input logic [POS_W-1:0] pos);
      logic [ADDR_W+RUN_W-1:0] a;
      a = ADDR_W'(r) * (ADDR_W+RUN_W)'(RUN_LEN) + (ADDR_W+RUN_W)'(pos);
      return a[ADDR_W-1:0];
   endfunction
endpackage
`default_nettype wire

// ===== design/rskm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rskm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== design/run_sort_and_kway_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Payload  | Handshake
// req     | in  | req_type | req_valid / req_ready
// rsp     | out | rsp_type | rsp_valid / rsp_ready
//
// Load: one item per cycle. Read while loading, or after the end: no result.
// After the last load each run is bubble-sorted through the single-port-write
// store, each compare stepping through the states read upper, read lower and
// compare/swap; req_ready is low throughout.
// Merge read: one store read per run head, scanned serially.
// Reset is synchronous; the store needs none (written before read).
// A finished item sits in the rsp register; the next req is taken only once it drains.
module run_sort_and_kway_merge (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rskm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rskm_pkg::rsp_type      rsp_data
);
   import rskm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SRD_HI, S_SRD_LO, S_SCMP, S_MRD, S_MCMP, S_MOUT
   } state_type;

   state_type            state_ff;
   logic [CNT_W-1:0]     load_cnt_ff, emit_cnt_ff;
   logic                 merging_ff;
   logic [RUN_W-1:0]     run_ff, best_run_ff;
   logic [POS_W-1:0]     wall_ff, pos_ff;
   logic [VAL_W-1:0]     hi_ff, best_ff;
   logic                 found_ff;
   logic [HEAD_W-1:0]    heads_ff [NUM_RUNS];
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr, rd_addr;
   logic [VAL_W-1:0]     wr_data, rd_data;
   logic                 accept;

   // second half of the swap is written in the cycle after S_SCMP
   logic             swap2_ff;
   logic [ADDR_W-1:0] swap2_addr_ff;
   logic [VAL_W-1:0]  swap2_data_ff;

   // a read issued while the second swap write hits the same entry
   // returns stale data; forward the written value instead
   logic             fwd_ff;
   logic [VAL_W-1:0] fwd_data_ff;
   logic [VAL_W-1:0] rd_value;

   logic             wr_en_q;
   logic [ADDR_W-1:0] wr_addr_q;
   logic [VAL_W-1:0]  wr_data_q;

   rskm_ram #(.WIDTH(VAL_W), .DEPTH(TOTAL_LEN)) u_store (
      .clock(clock), .wr_en(wr_en_q), .wr_addr(wr_addr_q), .wr_data(wr_data_q),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rd_value  = fwd_ff ? fwd_data_ff : rd_data;

   logic swap;
   assign swap = (state_ff == S_SCMP) && (hi_ff < rd_value);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ADDR_W'(load_cnt_ff);
      wr_data = req_data.value;
      rd_addr = run_addr(run_ff, pos_ff);
      if (accept && req_data.command == CMD_LOAD && !merging_ff) begin
         wr_en = 1'b1;
      end else if (state_ff == S_SRD_LO) begin
         rd_addr = run_addr(run_ff, pos_ff - POS_W'(1));
      end else if (state_ff == S_SCMP) begin
         // first write of a swap: larger value moves up
         wr_en   = swap;
         wr_addr = run_addr(run_ff, pos_ff);
         wr_data = rd_value;
      end else if (state_ff == S_MRD || state_ff == S_MCMP) begin
         rd_addr = run_addr(run_ff, heads_ff[run_ff][POS_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      swap2_ff      <= !reset && swap;
      swap2_addr_ff <= run_addr(run_ff, pos_ff - POS_W'(1));
      swap2_data_ff <= hi_ff;
      fwd_ff        <= !reset && swap2_ff && (swap2_addr_ff == rd_addr);
      fwd_data_ff   <= swap2_data_ff;
      if (reset) begin
         state_ff     <= S_IDLE;
         load_cnt_ff  <= '0;
         emit_cnt_ff  <= '0;
         merging_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         run_ff       <= '0;
         for (int i = 0; i < NUM_RUNS; i++) heads_ff[i] <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_data.command == CMD_LOAD && !merging_ff) begin
                     load_cnt_ff <= load_cnt_ff + CNT_W'(1);
                     if (load_cnt_ff == CNT_W'(TOTAL_LEN - 1)) begin
                        merging_ff <= 1'b1;
                        run_ff     <= '0;
                        wall_ff    <= '0;
                        pos_ff     <= POS_W'(RUN_LEN - 1);
                        state_ff   <= S_SRD_HI;
                     end
                  end else if (req_data.command == CMD_READ && merging_ff &&
                               emit_cnt_ff != CNT_W'(TOTAL_LEN)) begin
                     run_ff   <= '0;
                     found_ff <= 1'b0;
                     state_ff <= S_MRD;
                  end
               end
            end
            S_SRD_HI: state_ff <= S_SRD_LO;
            S_SRD_LO: begin
               hi_ff    <= rd_value;
               state_ff <= S_SCMP;
            end
            S_SCMP: begin
               if (pos_ff - POS_W'(1) != wall_ff) begin
                  pos_ff   <= pos_ff - POS_W'(1);
                  state_ff <= S_SRD_HI;
               end else if (wall_ff != POS_W'(RUN_LEN - 2)) begin
                  wall_ff  <= wall_ff + POS_W'(1);
                  pos_ff   <= POS_W'(RUN_LEN - 1);
                  state_ff <= S_SRD_HI;
               end else if (run_ff != RUN_W'(NUM_RUNS - 1)) begin
                  run_ff   <= run_ff + RUN_W'(1);
                  wall_ff  <= '0;
                  pos_ff   <= POS_W'(RUN_LEN - 1);
                  state_ff <= S_SRD_HI;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_MRD: state_ff <= S_MCMP;
            S_MCMP: begin
               if (heads_ff[run_ff] != HEAD_W'(RUN_LEN) &&
                   (!found_ff || rd_value < best_ff)) begin
                  found_ff    <= 1'b1;
                  best_ff     <= rd_value;
                  best_run_ff <= run_ff;
               end
               if (run_ff == RUN_W'(NUM_RUNS - 1)) begin
                  state_ff <= S_MOUT;
               end else begin
                  run_ff   <= run_ff + RUN_W'(1);
                  state_ff <= S_MRD;
               end
            end
            S_MOUT: begin
               heads_ff[best_run_ff] <= heads_ff[best_run_ff] + HEAD_W'(1);
               emit_cnt_ff           <= emit_cnt_ff + CNT_W'(1);
               rsp_ff.sorted_value   <= best_ff;
               rsp_ff.is_last        <= (emit_cnt_ff == CNT_W'(TOTAL_LEN - 1));
               rsp_valid_ff          <= 1'b1;
               state_ff              <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // The store has one write port: the second swap write uses it in the cycle after
   // S_SCMP (S_SRD_HI or S_IDLE), which never write. Route it through a small mux.
   always_comb begin
      wr_en_q   = wr_en || swap2_ff;
      wr_addr_q = swap2_ff ? swap2_addr_ff : wr_addr;
      wr_data_q = swap2_ff ? swap2_data_ff : wr_data;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("rsp item dropped");
   assert property (@(posedge clock) disable iff (reset)
      swap2_ff |-> !wr_en)
      else $error("store write collision");
   assert property (@(posedge clock) disable iff (reset)
      emit_cnt_ff != '0 |-> merging_ff)
      else $error("merge before store full");
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import rskm_pkg::*;

   // Watchdog limit in cycles with no accepted item. The in-place sort of all
   // runs keeps the input closed, so the limit sits well above that whole pass.
   localparam int IDLE_LIMIT = 6 * NUM_RUNS * RUN_LEN * RUN_LEN;
   localparam int LONG_HOLD  = 400;
   localparam int DRAIN_WAIT = 200;

   typedef enum logic [1:0] {ST_LOADING, ST_MERGING, ST_FINISHED} merge_state_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   run_sort_and_kway_merge dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor: own copy of the store, run heads and counters
   // ---------------------------------------------------------------
   logic [VAL_W-1:0] shadow_store [TOTAL_LEN];
   int               head_pos [NUM_RUNS];
   int               loaded_cnt  = 0;
   int               merged_cnt  = 0;
   merge_state_type  merge_state = ST_LOADING;
   rsp_type          pending_merge_q [$];

   int  error_cnt = 0;
   bit  long_hold_req = 1'b0;
   bit  item_taken;

   // sort every run ascending; same final order as the block's bubble sort
   task automatic sort_shadow_runs();
      logic [VAL_W-1:0] run_vals [$];
      for (int r = 0; r < NUM_RUNS; r++) begin
         run_vals.delete();
         for (int p = 0; p < RUN_LEN; p++) run_vals.push_back(shadow_store[r*RUN_LEN+p]);
         run_vals.sort();
         for (int p = 0; p < RUN_LEN; p++) shadow_store[r*RUN_LEN+p] = run_vals[p];
      end
   endtask

   task automatic predict_merge(input req_type it);
      bit               found;
      logic [VAL_W-1:0] best;
      int               best_run;
      rsp_type          exp_rsp;
      if (it.command == CMD_LOAD) begin
         // loads are dropped once the store is full
         if (merge_state == ST_LOADING) begin
            shadow_store[loaded_cnt] = it.value;
            loaded_cnt++;
            if (loaded_cnt == TOTAL_LEN) begin
               sort_shadow_runs();
               merge_state = ST_MERGING;
            end
         end
      end else if (merge_state == ST_MERGING) begin
         found = 1'b0;
         best = '0;
         best_run = 0;
         // strict less-than keeps ties on the lowest run
         for (int r = 0; r < NUM_RUNS; r++) begin
            if (head_pos[r] < RUN_LEN) begin
               if (!found || shadow_store[r*RUN_LEN+head_pos[r]] < best) begin
                  found = 1'b1;
                  best = shadow_store[r*RUN_LEN+head_pos[r]];
                  best_run = r;
               end
            end
         end
         if (found) begin
            head_pos[best_run]++;
            merged_cnt++;
            exp_rsp.sorted_value = best;
            exp_rsp.is_last = (merged_cnt == TOTAL_LEN);
            pending_merge_q.push_back(exp_rsp);
            if (merged_cnt == TOTAL_LEN) merge_state = ST_FINISHED;
         end
      end
      // reads while loading or after the end give nothing
   endtask

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_cnt++;
   endtask

   // ---------------------------------------------------------------
   // Sender: bursts of random length with random gaps
   // ---------------------------------------------------------------
   int burst_left = 0;

   task automatic send_item(input logic cmd, input logic [VAL_W-1:0] val);
      req_type it;
      int      gap;
      it.command = cmd;
      it.value = val;
      if (burst_left == 0) begin
         // one in four bursts is long and back to back
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                 : $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_merge(it);
   endtask

   task automatic idle_sender();
      req_valid <= 1'b0;
      burst_left = 0;
   endtask

   // ---------------------------------------------------------------
   // Receiver: own stall pattern, check on every accepted result
   // ---------------------------------------------------------------
   logic [15:0] ready_pattern = 16'hffff;
   int          pattern_age = 0;
   int          hold_left = 0;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_merge_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item value=%0d last=%0b",
                                      rsp_data.sorted_value, rsp_data.is_last));
         end else begin
            if (rsp_data.sorted_value !== pending_merge_q[0].sorted_value)
               report_mismatch($sformatf("sorted_value got %0d want %0d",
                                         rsp_data.sorted_value,
                                         pending_merge_q[0].sorted_value));
            if (rsp_data.is_last !== pending_merge_q[0].is_last)
               report_mismatch($sformatf("is_last got %0b want %0b",
                                         rsp_data.is_last, pending_merge_q[0].is_last));
            void'(pending_merge_q.pop_front());
         end
      end
      // long hold-off on request, so the block backs up into its input
      if (long_hold_req && hold_left == 0) begin
         hold_left = LONG_HOLD;
         long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
               0: ready_pattern = 16'hffff;
               1: ready_pattern = 16'h0f0f;
               default: ready_pattern = 16'($urandom());
            endcase
            pattern_age = $urandom_range(16, 200);
         end
         pattern_age--;
         ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
         rsp_ready <= ready_pattern[0];
      end
   end

   // ---------------------------------------------------------------
   // Watchdog: cycles with nothing accepted on either channel
   // ---------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      item_taken = (req_valid && req_ready) || (rsp_valid && rsp_ready);
      if (reset || item_taken) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", idle_cycles);
         $display("run_sort_and_kway_merge test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // reads before any load must give nothing
   task automatic test_read_while_loading();
      for (int i = 0; i < 6; i++) send_item(CMD_READ, VAL_W'($urandom()));
   endtask

   // value for position p of run r; each run has its own flavor
   function automatic logic [VAL_W-1:0] pick_load_value(input int r, input int p);
      case (r)
         0: begin
            // extremes and alternating bits first
            case (p)
               0: return '0;
               1: return '1;
               2: return 15'h5555;
               3: return 15'h2aaa;
               4: return '1;
               5: return '0;
               default: return VAL_W'($urandom());
            endcase
         end
         1: return VAL_W'(32767 - p * 97);             // strictly descending
         2: return 15'd7;                             // one value, ties with run 3
         3: return VAL_W'($urandom_range(5, 9));
         4: return ($urandom_range(0, 1) == 0) ? '0 : '1;
         5: return VAL_W'(p);                         // already sorted
         default: return VAL_W'($urandom());
      endcase
   endfunction

   // fill the store; stray reads mixed in are ignored by the block
   task automatic test_load_store();
      for (int r = 0; r < NUM_RUNS; r++) begin
         for (int p = 0; p < RUN_LEN; p++) begin
            if ($urandom_range(0, 40) == 0) send_item(CMD_READ, VAL_W'($urandom()));
            send_item(CMD_LOAD, pick_load_value(r, p));
         end
      end
   endtask

   // drain the merge; stray loads are ignored, one long receiver hold-off
   task automatic test_merge_reads();
      for (int i = 0; i < TOTAL_LEN; i++) begin
         if (i == 300) long_hold_req = 1'b1;
         if ($urandom_range(0, 30) == 0) send_item(CMD_LOAD, VAL_W'($urandom()));
         send_item(CMD_READ, VAL_W'($urandom()));
      end
   endtask

   // reads and loads after the last value give nothing
   task automatic test_after_done();
      for (int i = 0; i < 10; i++) send_item(1'($urandom()), VAL_W'($urandom()));
   endtask

   initial begin
      for (int r = 0; r < NUM_RUNS; r++) head_pos[r] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_read_while_loading();
      test_load_store();
      test_merge_reads();
      test_after_done();
      idle_sender();

      while (pending_merge_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_cnt == 0) begin
         $display("run_sort_and_kway_merge test passed");
      end else begin
         $display("run_sort_and_kway_merge test failed");
      end
      $finish;
   end
endmodule
